// ===== rtl/wpm_pkg.sv =====
// Shared types and constants for the wildcard pattern matcher.
// Used by wpm_front, wpm_back and wildcard_pattern_matcher_core; no dependencies.
package wpm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SYM_W       = 8;
    localparam int OP_W        = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SYM_W-1:0] STAR_RESET    = 8'd42;
    localparam logic [SYM_W-1:0] ANY_ONE_RESET = 8'd63;

    // configuration register indexes
    localparam logic CFG_STAR_CODE    = 1'b0;
    localparam logic CFG_ANY_ONE_CODE = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_FINISH = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] symbol;
    } t_cmd;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_result;

endpackage

// ===== rtl/wpm_front.sv =====
// Front end of the wildcard pattern matcher: decodes input beats into commands
// and holds them in a short queue for the back end. Depends on wpm_pkg.
module wpm_front
    import wpm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [SYM_W-1:0] s_axis_tdata,
    input  logic [OP_W-1:0]  s_axis_tuser,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output t_cmd             o_cmd
);

    t_cmd              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_count, n_count;
    t_cmd              w_cmd;
    logic              w_push;
    logic              w_pop;

    // classify the beat; drop the symbol where the opcode ignores it
    always_comb begin
        w_cmd.op     = t_op'(s_axis_tuser);
        w_cmd.symbol = s_axis_tdata;
        case (w_cmd.op)
            OP_APPEND, OP_TEXT: w_cmd.symbol = s_axis_tdata;
            default:            w_cmd.symbol = '0;
        endcase
    end

    assign s_axis_tready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_count != '0);
    assign w_pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd         = r_queue[r_rp];

    always_comb begin
        n_wp    = w_push ? r_wp + 1'b1 : r_wp;
        n_rp    = w_pop  ? r_rp + 1'b1 : r_rp;
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wp] <= w_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/wpm_back.sv =====
// Back end of the wildcard pattern matcher: pattern lanes, active-position set
// with star closure, configuration registers and the result register. Uses wpm_pkg.
module wpm_back
    import wpm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [SYM_W-1:0] i_cfg_wdata,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  t_cmd             i_cmd,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    logic [SYM_W-1:0]     r_char [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_used;
    logic [LEN_W-1:0]     r_len;
    logic                 r_ovf;
    logic [MAX_PATTERN:0] r_raw, n_raw;
    logic [SYM_W-1:0]     r_star_code;
    logic [SYM_W-1:0]     r_any_code;
    logic                 r_out_valid;
    t_result              r_out;

    logic [MAX_PATTERN:0]   w_star;
    logic [MAX_PATTERN:0]   w_gen;
    logic [MAX_PATTERN:0]   w_sum;
    logic [MAX_PATTERN:0]   w_closed;
    logic [MAX_PATTERN:0]   w_stay;
    logic [MAX_PATTERN-1:0] w_adv;
    logic                   w_pop;
    logic                   w_full;
    logic                   w_hit;

    // per-lane star flag; positions past the pattern never count
    always_comb begin
        w_star = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_star[i] = r_used[i] && (r_char[i] == r_star_code);
        end
    end

    // closure over runs of stars as a carry chain: generate where an active
    // position is a star, propagate through every star
    assign w_gen    = r_raw & w_star;
    assign w_sum    = w_gen + w_star;
    assign w_closed = r_raw | (w_sum ^ w_gen ^ w_star);

    // one text byte: stars hold, other matching lanes advance one position
    always_comb begin
        w_adv = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_adv[i] = w_closed[i] && r_used[i] && !w_star[i]
                    && (r_char[i] == r_any_code || r_char[i] == i_cmd.symbol);
        end
    end
    assign w_stay = w_closed & w_star;

    assign w_hit  = w_closed[r_len] && !r_ovf;
    assign w_full = (r_len == LEN_W'(MAX_PATTERN));

    assign o_cmd_ready = (i_cmd.op != OP_FINISH) || !r_out_valid || i_res_ready;
    assign w_pop       = i_cmd_valid && o_cmd_ready;

    always_comb begin
        n_raw = r_raw;
        if (w_pop) begin
            case (i_cmd.op)
                OP_TEXT: n_raw = w_stay | {w_adv, 1'b0};
                default: n_raw = (MAX_PATTERN + 1)'(1);
            endcase
        end
        if (i_cfg_we) begin
            n_raw = (MAX_PATTERN + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_raw       <= (MAX_PATTERN + 1)'(1);
            r_star_code <= STAR_RESET;
            r_any_code  <= ANY_ONE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_raw <= n_raw;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_STAR_CODE:    r_star_code <= i_cfg_wdata;
                    CFG_ANY_ONE_CODE: r_any_code  <= i_cfg_wdata;
                    default:          r_star_code <= r_star_code;
                endcase
            end
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_pop) begin
                case (i_cmd.op)
                    OP_CLEAR: begin
                        r_used <= '0;
                        r_len  <= '0;
                        r_ovf  <= 1'b0;
                    end
                    OP_APPEND: begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_used[r_len[IDX_W-1:0]] <= 1'b1;
                            r_len                    <= r_len + 1'b1;
                        end
                    end
                    OP_FINISH: r_out_valid <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // payload registers: pattern lanes and the result
    always_ff @(posedge i_clk) begin
        if (w_pop && i_cmd.op == OP_APPEND && !w_full) begin
            r_char[r_len[IDX_W-1:0]] <= i_cmd.symbol;
        end
        if (w_pop && i_cmd.op == OP_FINISH) begin
            r_out.matched          <= w_hit;
            r_out.pattern_overflow <= r_ovf;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`ifndef NO_ASSERTIONS
    a_used_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_len))
        else $error("lane use mask disagrees with pattern length");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_cmd.op == OP_FINISH) |=> r_out_valid)
        else $error("finish popped without a result");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule

// ===== rtl/wildcard_pattern_matcher_core.sv =====
// Top level of the wildcard pattern matcher: front-end queue plus matching engine.
// Depends on wpm_pkg, wpm_front and wpm_back.
//
// Usage:
//   Input stream (s_axis): one beat per command. tuser carries the opcode
//   (clear, append pattern char, text char, finish), tdata the character.
//   Output stream (m_axis): one beat per finish command; tdata bit 0 is the
//   match flag, bit 1 the pattern overflow flag.
//   Config port: i_cfg_we with i_cfg_addr 0 writes the star code, 1 the
//   single-character wildcard code; either write restarts text tracking.
//   Write it only while no command is in flight.
// Throughput: one beat per cycle for every opcode while m_axis_tready is high;
//   each text byte updates all 64 pattern lanes at once; the star closure
//   is one 65-bit carry chain in the engine and sets the clock-to-clock path.
// Result path: a finish beat accepted on s_axis passes the queue register,
//   then the result register, before its result shows on m_axis.
// Reset: pattern empty, overflow clear, star code 42, wildcard code 63,
//   queue and result register empty.
// Stall: the result register holds while m_axis_tready is low; the engine
//   keeps executing non-finish commands, stops at the next finish, and the
//   four-entry queue then fills before s_axis_tready drops.
module wildcard_pattern_matcher_core
    import wpm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [SYM_W-1:0] i_cfg_wdata,
    // command stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] symbol
    input  logic [1:0]       s_axis_tuser,   // [1:0] opcode
    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    logic    w_cmd_valid;
    logic    w_cmd_ready;
    t_cmd    w_cmd;
    t_result w_res;

    // accept and queue commands
    wpm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    // execute commands against the pattern lanes; hold results for the sink
    wpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    // pack result fields from bit 0 up, zero-fill to a byte
    assign m_axis_tdata = {6'b0, w_res.pattern_overflow, w_res.matched};

endmodule
